>>> design/nss_pkg.sv
// Package for the nearest segment search block: widths, command codes, types.
// No dependencies.
`default_nettype none
package nss_pkg;
    localparam int MaxSegments = 64;
    localparam int CoordWidth  = 16;
    localparam int SlotWidth   = 6;
    localparam int QueueDepth  = 2;

    typedef enum logic {
        CMD_ADD   = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef logic signed [CoordWidth-1:0] coord_t;

    // One beat as it travels from the front to the back part
    typedef struct packed {
        logic                 is_query;
        logic [SlotWidth-1:0] slot;
        coord_t               ax;
        coord_t               ay;
        coord_t               bx;
        coord_t               by;
        coord_t               px;
        coord_t               py;
    } beat_t;

    // Segment table entry: start and end point
    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
    } seg_t;
endpackage
`default_nettype wire

>>> design/nss_ram.sv
// Generic RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module nss_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> design/nss_front.sv
// Front part: accepts input beats and queues them for the back part.
// Depends on nss_pkg.
`default_nettype none
module nss_front
    import nss_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire beat_t in_beat,
    output logic       q_valid,
    input  wire logic  q_pop,
    output beat_t      q_beat
);
    beat_t               buf_reg [QueueDepth];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic                push;

    assign in_stall = (cnt_reg == 2'(QueueDepth));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_beat   = buf_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= in_beat;
        end
    end
endmodule
`default_nettype wire

>>> design/nss_back.sv
// Back part: writes segments, scans the table for a query, holds the result.
// Depends on nss_pkg and nss_ram.
`default_nettype none
module nss_back
    import nss_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               q_pop,
    input  wire beat_t         q_beat,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic               found,
    output logic [SlotWidth-1:0] nearest_slot,
    output coord_t             proj_x,
    output coord_t             proj_y
);
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_PREP  = 7'b0000100,
        ST_DOT   = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_PROJ  = 7'b0100000,
        ST_DIST  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [MaxSegments-1:0] valid_reg;
    logic [SlotWidth-1:0]   idx_reg;
    logic                   last_reg;
    logic signed [17:0]     px_reg, py_reg;
    seg_t                   seg_rd;
    logic [63:0]            seg_rd_raw;
    logic                   ram_we;

    // Per-segment arithmetic registers
    logic signed [17:0] abx_reg, aby_reg, apx_reg, apy_reg;
    logic signed [35:0] m0_reg, m1_reg, m2_reg, m3_reg;
    logic [35:0]        len_reg;
    logic signed [36:0] dot_reg;
    logic [36:0]        rem_reg;
    logic [15:0]        t_reg;
    logic [4:0]         step_reg;
    logic signed [17:0] qx_reg, qy_reg;
    logic signed [35:0] mx_reg, my_reg;
    logic               mul_phase_reg;

    // Best so far and output register
    logic               best_found_reg;
    logic [37:0]        best_d_reg;
    logic [SlotWidth-1:0] best_slot_reg;
    coord_t             best_x_reg, best_y_reg;
    logic               out_valid_reg;

    nss_ram #(.Width(64), .Depth(MaxSegments)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_beat.slot),
        .wdata ({q_beat.ax, q_beat.ay, q_beat.bx, q_beat.by}),
        .raddr (idx_reg),
        .rdata (seg_rd_raw)
    );
    assign seg_rd = seg_t'(seg_rd_raw);

    assign out_valid    = out_valid_reg;
    assign found        = best_found_reg;
    assign nearest_slot = best_slot_reg;
    assign proj_x       = best_x_reg;
    assign proj_y       = best_y_reg;

    logic start_ok;
    assign start_ok = q_valid && (state_reg == ST_IDLE) &&
                      (!q_beat.is_query || !out_valid_reg || !out_stall);
    assign ram_we   = start_ok && !q_beat.is_query;
    assign q_pop    = start_ok;

    // Restoring division step and rounding
    logic [37:0] rem_sh;
    logic signed [35:0] rx, ry;
    logic signed [17:0] dx, dy;
    assign rem_sh = {rem_reg, 1'b0};
    assign rx = (mx_reg + 36'sd32768) >>> 16;
    assign ry = (my_reg + 36'sd32768) >>> 16;
    assign dx = px_reg - qx_reg;
    assign dy = py_reg - qy_reg;

    logic [37:0] dist2;
    assign dist2 = 38'(unsigned'(36'(mx_reg))) + 38'(unsigned'(36'(my_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (start_ok && !q_beat.is_query)
                    begin
                        valid_reg[q_beat.slot] <= 1'b1;
                    end
                    else if (start_ok)
                    begin
                        px_reg         <= 18'(q_beat.px);
                        py_reg         <= 18'(q_beat.py);
                        best_found_reg <= 1'b0;
                        best_slot_reg  <= '0;
                        best_x_reg     <= '0;
                        best_y_reg     <= '0;
                        idx_reg        <= '0;
                        state_reg      <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    // Skip empty slots; RAM data arrives next cycle
                    last_reg <= (idx_reg == SlotWidth'(MaxSegments - 1));
                    if (valid_reg[idx_reg])
                    begin
                        state_reg <= ST_PREP;
                    end
                    else if (idx_reg == SlotWidth'(MaxSegments - 1))
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + SlotWidth'(1);
                    end
                end
                ST_PREP:
                begin
                    abx_reg <= 18'(seg_rd.bx) - 18'(seg_rd.ax);
                    aby_reg <= 18'(seg_rd.by) - 18'(seg_rd.ay);
                    apx_reg <= px_reg - 18'(seg_rd.ax);
                    apy_reg <= py_reg - 18'(seg_rd.ay);
                    mul_phase_reg <= 1'b0;
                    state_reg <= ST_DOT;
                end
                ST_DOT:
                begin
                    // Multiply in the first phase, then combine
                    if (!mul_phase_reg)
                    begin
                        m0_reg <= abx_reg * abx_reg;
                        m1_reg <= aby_reg * aby_reg;
                        m2_reg <= apx_reg * abx_reg;
                        m3_reg <= apy_reg * aby_reg;
                        mul_phase_reg <= 1'b1;
                    end
                    else
                    begin
                        len_reg  <= 36'(m0_reg) + 36'(m1_reg);
                        dot_reg  <= 37'(m2_reg) + 37'(m3_reg);
                        step_reg <= '0;
                        t_reg    <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (step_reg == 5'd0)
                    begin
                        rem_reg <= unsigned'(dot_reg);
                        if (len_reg == 36'd0 || dot_reg <= 37'sd0)
                        begin
                            qx_reg    <= abx_reg - abx_reg + 18'(seg_rd.ax);
                            qy_reg    <= 18'(seg_rd.ay);
                            mx_reg    <= '0;
                            my_reg    <= '0;
                            step_reg  <= 5'd17;
                            mul_phase_reg <= 1'b1;
                        end
                        else if (dot_reg >= signed'(37'(len_reg)))
                        begin
                            qx_reg    <= 18'(seg_rd.bx);
                            qy_reg    <= 18'(seg_rd.by);
                            step_reg  <= 5'd17;
                            mul_phase_reg <= 1'b1;
                        end
                        else
                        begin
                            step_reg <= 5'd1;
                            mul_phase_reg <= 1'b0;
                        end
                    end
                    else if (step_reg == 5'd17)
                    begin
                        state_reg <= ST_PROJ;
                    end
                    else
                    begin
                        if (rem_sh >= 38'(len_reg))
                        begin
                            rem_reg <= 37'(rem_sh - 38'(len_reg));
                            t_reg   <= {t_reg[14:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh[36:0];
                            t_reg   <= {t_reg[14:0], 1'b0};
                        end
                        step_reg <= step_reg + 5'd1;
                    end
                end
                ST_PROJ:
                begin
                    // Interior: multiply then round; end cases already hold q
                    if (!mul_phase_reg)
                    begin
                        mx_reg <= abx_reg * signed'({2'b00, t_reg});
                        my_reg <= aby_reg * signed'({2'b00, t_reg});
                        mul_phase_reg <= 1'b1;
                        step_reg <= 5'd0;
                    end
                    else if (step_reg == 5'd0)
                    begin
                        qx_reg   <= 18'(seg_rd.ax) + 18'(rx);
                        qy_reg   <= 18'(seg_rd.ay) + 18'(ry);
                        step_reg <= 5'd1;
                    end
                    else
                    begin
                        mx_reg    <= dx * dx;
                        my_reg    <= dy * dy;
                        state_reg <= ST_DIST;
                    end
                end
                ST_DIST:
                begin
                    if (!best_found_reg || dist2 < best_d_reg)
                    begin
                        best_found_reg <= 1'b1;
                        best_d_reg     <= dist2;
                        best_slot_reg  <= idx_reg;
                        best_x_reg     <= coord_t'(qx_reg);
                        best_y_reg     <= coord_t'(qy_reg);
                    end
                    if (last_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + SlotWidth'(1);
                        state_reg <= ST_READ;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

>>> design/nearest_segment_search.sv
// Nearest segment search, top level: front queue plus scanning back part.
// Depends on nss_pkg, nss_front, nss_back, nss_ram.
// An add is written once the idle back part pops it. A query scans every slot, skips
// empty ones and takes valid ones through prep, dot, div, proj and dist (no division
// steps if t is clamped). One query at a time in the back part; the two-entry queue
// takes beats meanwhile. Reset clears valid bits and control state at once.
`default_nettype none
module nearest_segment_search
    import nss_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire logic  command,
    input  wire logic [SlotWidth-1:0] road_slot,
    input  wire coord_t start_x,
    input  wire coord_t start_y,
    input  wire coord_t end_x,
    input  wire coord_t end_y,
    input  wire coord_t point_x,
    input  wire coord_t point_y,
    output logic       out_valid,
    input  wire logic  out_stall,
    output logic       found,
    output logic [SlotWidth-1:0] nearest_slot,
    output coord_t     proj_x,
    output coord_t     proj_y
);
    beat_t in_beat, q_beat;
    logic  q_valid, q_pop;

    assign in_beat = '{is_query: (cmd_t'(command) == CMD_QUERY), slot: road_slot,
                       ax: start_x, ay: start_y, bx: end_x, by: end_y,
                       px: point_x, py: point_y};

    nss_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .in_beat,
        .q_valid, .q_pop, .q_beat
    );

    nss_back u_back (
        .clk, .rst_n, .q_valid, .q_pop, .q_beat,
        .out_valid, .out_stall, .found, .nearest_slot, .proj_x, .proj_y
    );

`ifndef SYNTH
    // An empty result reports slot zero and the origin
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (nearest_slot == '0 && proj_x == '0 && proj_y == '0))
        else $error("empty result not cleared");
    // A held result stays valid and keeps its slot while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(nearest_slot)))
        else $error("result changed under stall");
`endif
endmodule
`default_nettype wire
